### rtl/popa_pkg.sv
// Shared types, constants and helper functions for the paged object pool allocator.
// Used by popa_ctrl, popa_dpath, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
package popa_pkg;

  localparam int MAX_PAGES          = 16;
  localparam int MAX_SLOTS_PER_PAGE = 32;
  localparam int MAX_STRIDE         = 1024;
  localparam int SLOT_CAP           = MAX_PAGES * MAX_SLOTS_PER_PAGE;
  localparam int SLOT_W             = $clog2(SLOT_CAP);
  localparam int CNT_W              = $clog2(SLOT_CAP + 1);
  localparam int ADDR_W             = 19;
  localparam int NUM_W              = 32;
  localparam int PAGE_W             = 5;
  localparam int PPG_W              = 6;
  localparam int LIM_W              = 5;
  localparam int STRIDE_W           = 11;
  localparam int DIV_STEPS          = ADDR_W;
  localparam int DIV_CNT_W          = $clog2(DIV_STEPS + 1);
  localparam int CFG_AW             = 4;

  localparam logic [1:0] REG_PER_PAGE = 2'd0;
  localparam logic [1:0] REG_LIMIT    = 2'd1;
  localparam logic [1:0] REG_CHECK    = 2'd2;
  localparam logic [1:0] REG_STRIDE   = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_NO_PAGE = 2'd1,
    ERR_BOUND   = 2'd2,
    ERR_DOUBLE  = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_PAGE_START,
    OP_PAGE_PUSH,
    OP_PAGE_END,
    OP_POP_COMMIT,
    OP_DIV_STEP,
    OP_FREE_COMMIT,
    OP_FREE_SKIP,
    OP_ERR_NO_PAGE,
    OP_ERR_BOUND,
    OP_ERR_DOUBLE
  } dp_op_t;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   object_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   given_address;
    logic [NUM_W-1:0]    given_number;
    logic [1:0]          error_code;
    logic [CNT_W-1:0]    count_in_use;
    logic [CNT_W-1:0]    count_free;
    logic [PAGE_W-1:0]   count_pages;
    logic [CNT_W-1:0]    peak_in_use;
    logic [NUM_W-1:0]    total_allocations;
    logic [NUM_W-1:0]    total_frees;
  } result_t;

  typedef struct packed {
    logic [PPG_W-1:0]    objects_per_page;
    logic [LIM_W-1:0]    page_limit;
    logic                checking_on;
    logic [STRIDE_W-1:0] slot_stride;
  } cfg_t;

  typedef struct packed {
    logic stack_empty;
    logic limit_hit;
    logic fill_done;
    logic div_done;
    logic bad_align;
    logic out_of_range;
    logic checking;
    logic slot_busy;
  } status_t;

  function automatic logic [PPG_W-1:0] eff_per_page(input logic [PPG_W-1:0] v);
    if (v == '0) return PPG_W'(1);
    if (v > PPG_W'(MAX_SLOTS_PER_PAGE)) return PPG_W'(MAX_SLOTS_PER_PAGE);
    return v;
  endfunction

  function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] v);
    if (v == '0) return STRIDE_W'(1);
    if (v > STRIDE_W'(MAX_STRIDE)) return STRIDE_W'(MAX_STRIDE);
    return v;
  endfunction

  function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] v);
    if (v == '0 || v > LIM_W'(MAX_PAGES)) return LIM_W'(MAX_PAGES);
    return v;
  endfunction

endpackage

### rtl/popa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module popa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### rtl/popa_dpath.sv
// Datapath: free stack and in-use memories, counters, divider and result registers.
// Depends on popa_pkg and popa_ram; driven by ops from popa_ctrl.
`timescale 1ns / 1ps
module popa_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  popa_pkg::dp_op_t op,
  input  popa_pkg::req_t   req,
  input  popa_pkg::cfg_t   cfg,
  output popa_pkg::status_t status,
  output popa_pkg::result_t result
);
  import popa_pkg::*;

  logic [CNT_W-1:0]     depth_r, depth_nxt;
  logic [CNT_W-1:0]     built_r, built_nxt;
  logic [CNT_W-1:0]     live_r, live_nxt;
  logic [CNT_W-1:0]     peak_r, peak_nxt;
  logic [PAGE_W-1:0]    pages_r, pages_nxt;
  logic [NUM_W-1:0]     alloc_r, alloc_nxt;
  logic [NUM_W-1:0]     frees_r, frees_nxt;
  logic [PPG_W-1:0]     fill_r, fill_nxt;
  logic [ADDR_W-1:0]    quo_r, quo_nxt;
  logic [STRIDE_W-1:0]  rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [ADDR_W-1:0]    raddr_r, raddr_nxt;
  logic [NUM_W-1:0]     rnum_r, rnum_nxt;
  err_t                 rerr_r, rerr_nxt;

  logic [STRIDE_W-1:0]  stride;
  logic [STRIDE_W:0]    trial;
  logic                 built_room;
  logic                 push_room;
  logic [SLOT_W-1:0]    pop_idx;
  logic                 inuse_bit;
  logic                 stack_we, inuse_we, inuse_wd;
  logic [SLOT_W-1:0]    stack_wd, inuse_wa;
  logic [SLOT_W+STRIDE_W-1:0] product;

  assign stride     = eff_stride(cfg.slot_stride);
  assign trial      = {rem_r, quo_r[ADDR_W-1]};
  assign built_room = built_r < CNT_W'(SLOT_CAP);
  assign push_room  = depth_r < built_r;
  assign product    = pop_idx * stride;

  // Writes: page fill pushes new slots, clearing their in-use bit; pop sets it; free clears it and re-pushes.
  always_comb begin
    stack_we = 1'b0;
    stack_wd = built_r[SLOT_W-1:0];
    inuse_we = 1'b0;
    inuse_wa = built_r[SLOT_W-1:0];
    inuse_wd = 1'b0;
    unique case (op)
      OP_PAGE_PUSH: begin
        stack_we = built_room;
        inuse_we = built_room;
      end
      OP_POP_COMMIT: begin
        inuse_we = 1'b1;
        inuse_wa = pop_idx;
        inuse_wd = 1'b1;
      end
      OP_FREE_COMMIT: begin
        stack_we = push_room;
        stack_wd = quo_r[SLOT_W-1:0];
        inuse_we = 1'b1;
        inuse_wa = quo_r[SLOT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  popa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_CAP)) u_stack (
    .clk     (clk),
    .wr_en   (stack_we),
    .wr_addr (depth_r[SLOT_W-1:0]),
    .wr_data (stack_wd),
    .rd_addr (SLOT_W'(depth_r - CNT_W'(1))),
    .rd_data (pop_idx)
  );

  popa_ram #(.WIDTH(1), .DEPTH(SLOT_CAP)) u_inuse (
    .clk     (clk),
    .wr_en   (inuse_we),
    .wr_addr (inuse_wa),
    .wr_data (inuse_wd),
    .rd_addr (quo_r[SLOT_W-1:0]),
    .rd_data (inuse_bit)
  );

  always_comb begin
    depth_nxt = depth_r;
    built_nxt = built_r;
    live_nxt  = live_r;
    peak_nxt  = peak_r;
    pages_nxt = pages_r;
    alloc_nxt = alloc_r;
    frees_nxt = frees_r;
    fill_nxt  = fill_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    raddr_nxt = raddr_r;
    rnum_nxt  = rnum_r;
    rerr_nxt  = rerr_r;
    unique case (op)
      OP_CAPTURE: begin
        quo_nxt  = req.object_address;
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      OP_PAGE_START: fill_nxt = eff_per_page(cfg.objects_per_page);
      OP_PAGE_PUSH: begin
        fill_nxt = fill_r - PPG_W'(1);
        if (built_room) begin
          depth_nxt = depth_r + CNT_W'(1);
          built_nxt = built_r + CNT_W'(1);
        end
      end
      OP_PAGE_END: pages_nxt = pages_r + PAGE_W'(1);
      OP_POP_COMMIT: begin
        depth_nxt = depth_r - CNT_W'(1);
        alloc_nxt = alloc_r + NUM_W'(1);
        if (live_r < CNT_W'(SLOT_CAP)) begin
          live_nxt = live_r + CNT_W'(1);
          if (live_r + CNT_W'(1) > peak_r) begin
            peak_nxt = live_r + CNT_W'(1);
          end
        end
        raddr_nxt = product[ADDR_W-1:0];
        rnum_nxt  = alloc_r + NUM_W'(1);
        rerr_nxt  = ERR_OK;
      end
      OP_DIV_STEP: begin
        // one quotient bit per cycle, restoring
        if (trial >= {1'b0, stride}) begin
          rem_nxt = STRIDE_W'(trial - {1'b0, stride});
          quo_nxt = {quo_r[ADDR_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[STRIDE_W-1:0];
          quo_nxt = {quo_r[ADDR_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
      end
      OP_FREE_COMMIT: begin
        if (push_room) begin
          depth_nxt = depth_r + CNT_W'(1);
        end
        if (live_r != '0) begin
          live_nxt = live_r - CNT_W'(1);
        end
        frees_nxt = frees_r + NUM_W'(1);
        raddr_nxt = '0;
        rnum_nxt  = '0;
        rerr_nxt  = ERR_OK;
      end
      OP_FREE_SKIP: begin
        raddr_nxt = '0;
        rnum_nxt  = '0;
        rerr_nxt  = ERR_OK;
      end
      OP_ERR_NO_PAGE: begin
        raddr_nxt = '0;
        rnum_nxt  = '0;
        rerr_nxt  = ERR_NO_PAGE;
      end
      OP_ERR_BOUND: begin
        raddr_nxt = '0;
        rnum_nxt  = '0;
        rerr_nxt  = ERR_BOUND;
      end
      OP_ERR_DOUBLE: begin
        raddr_nxt = '0;
        rnum_nxt  = '0;
        rerr_nxt  = ERR_DOUBLE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      built_r <= '0;
      live_r  <= '0;
      peak_r  <= '0;
      pages_r <= '0;
      alloc_r <= '0;
      frees_r <= '0;
      fill_r  <= '0;
      dcnt_r  <= '0;
      rerr_r  <= ERR_OK;
    end else begin
      depth_r <= depth_nxt;
      built_r <= built_nxt;
      live_r  <= live_nxt;
      peak_r  <= peak_nxt;
      pages_r <= pages_nxt;
      alloc_r <= alloc_nxt;
      frees_r <= frees_nxt;
      fill_r  <= fill_nxt;
      dcnt_r  <= dcnt_nxt;
      rerr_r  <= rerr_nxt;
    end
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    raddr_r <= raddr_nxt;
    rnum_r  <= rnum_nxt;
  end

  assign status.stack_empty  = depth_r == '0;
  assign status.limit_hit    = pages_r >= eff_limit(cfg.page_limit);
  assign status.fill_done    = fill_r == '0;
  assign status.div_done     = dcnt_r == DIV_CNT_W'(DIV_STEPS);
  assign status.bad_align    = rem_r != '0;
  assign status.out_of_range = quo_r >= ADDR_W'(built_r);
  assign status.checking     = cfg.checking_on;
  assign status.slot_busy    = inuse_bit;

  assign result.given_address     = raddr_r;
  assign result.given_number      = rnum_r;
  assign result.error_code        = rerr_r;
  assign result.count_in_use      = live_r;
  assign result.count_free        = depth_r;
  assign result.count_pages       = pages_r;
  assign result.peak_in_use       = peak_r;
  assign result.total_allocations = alloc_r;
  assign result.total_frees       = frees_r;
endmodule

### rtl/popa_ctrl.sv
// Controller state machine: sequences allocate, page fill, divide and free steps.
// Depends on popa_pkg; issues ops to popa_dpath and reads its status.
`timescale 1ns / 1ps
module popa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_kind,
  input  popa_pkg::status_t status,
  output popa_pkg::dp_op_t  op,
  output logic              busy,
  output logic              done
);
  import popa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FILL,
    S_AFTER_FILL,
    S_POP,
    S_DIV,
    S_FREE_DEC
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    done_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = OP_CAPTURE;
          state_nxt = (req_kind == KIND_FREE) ? S_DIV : S_ALLOC;
        end
      end
      S_ALLOC: begin
        priority if (!status.stack_empty) begin
          state_nxt = S_POP;
        end else if (status.limit_hit) begin
          op        = OP_ERR_NO_PAGE;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_PAGE_START;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (status.fill_done) begin
          op        = OP_PAGE_END;
          state_nxt = S_AFTER_FILL;
        end else begin
          op = OP_PAGE_PUSH;
        end
      end
      S_AFTER_FILL: begin
        if (status.stack_empty) begin
          op        = OP_ERR_NO_PAGE;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        op        = OP_POP_COMMIT;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        priority if (!status.div_done) begin
          op = OP_DIV_STEP;
        end else if (status.checking && (status.bad_align || status.out_of_range)) begin
          op        = OP_ERR_BOUND;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else if (status.out_of_range) begin
          op        = OP_FREE_SKIP;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FREE_DEC;
        end
      end
      S_FREE_DEC: begin
        op        = (status.checking && !status.slot_busy) ? OP_ERR_DOUBLE : OP_FREE_COMMIT;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = state_r != S_IDLE;
  assign done = done_r;
endmodule

### rtl/paged_object_pool_allocator.sv
// Top level of the paged object pool allocator: APB register file, controller, datapath.
// Depends on popa_pkg, popa_ctrl, popa_dpath (and popa_ram below it).
`timescale 1ns / 1ps
//
//  channel   | ports                           | handshake
//  ----------+---------------------------------+-------------------------------------
//  request   | start, busy, in_req             | item taken when start && !busy
//  result    | out_valid, out_result           | one-cycle strobe, no back-pressure
//  config    | psel penable pwrite paddr ...   | APB, write on access phase, pready=1
//
//  Allocate from a non-empty stack: S_ALLOC (stack read settles), then S_POP commits and strobes.
//  Allocate that adds a page: S_ALLOC, S_FILL at one push per cycle, S_AFTER_FILL, S_POP.
//  Free: bit-serial divide by the stride over every address bit, then S_DIV or S_FREE_DEC decides.
//  busy drops with the strobe, so the next item may be taken in the strobe cycle.
//  Synchronous active-low reset clears counters and restores config defaults; memories are not swept:
//  slots above the built count never read, and each page push clears its in-use bit.
//  The result side cannot stall; results are held only for their strobe cycle.
module paged_object_pool_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  popa_pkg::req_t                in_req,
  output logic                          out_valid,
  output popa_pkg::result_t             out_result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [popa_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import popa_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  status_t status;
  dp_op_t  op;
  logic    wr_hit;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_hit  = psel && penable && pwrite && pready;

  // Take register writes on the APB access phase; hold otherwise.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_hit) begin
      unique case (reg_idx)
        REG_PER_PAGE: cfg_nxt.objects_per_page = pwdata[PPG_W-1:0];
        REG_LIMIT:    cfg_nxt.page_limit       = pwdata[LIM_W-1:0];
        REG_CHECK:    cfg_nxt.checking_on      = pwdata[0];
        REG_STRIDE:   cfg_nxt.slot_stride      = pwdata[STRIDE_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PER_PAGE: prdata = 32'(cfg_r.objects_per_page);
      REG_LIMIT:    prdata = 32'(cfg_r.page_limit);
      REG_CHECK:    prdata = 32'(cfg_r.checking_on);
      REG_STRIDE:   prdata = 32'(cfg_r.slot_stride);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.objects_per_page <= PPG_W'(4);
      cfg_r.page_limit       <= '0;
      cfg_r.checking_on      <= 1'b0;
      cfg_r.slot_stride      <= STRIDE_W'(16);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  popa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_kind (in_req.kind),
    .status   (status),
    .op       (op),
    .busy     (busy),
    .done     (out_valid)
  );

  popa_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .req    (in_req),
    .cfg    (cfg_r),
    .status (status),
    .result (out_result)
  );

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in work");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.count_free <= {out_result.count_pages, 5'b0}))
    else $error("free stack deeper than the slots built by the pages");
`endif
endmodule

### tb/tb_paged_object_pool_allocator.sv
// Self-checking testbench for the paged object pool allocator.
// Depends on popa_pkg and the RTL top paged_object_pool_allocator only.
`timescale 1ns / 1ps

// Tracks the pool the way the block should, and holds the results still owed.
class pool_scoreboard;
  int unsigned per_page, page_cap, checks, stride_reg;
  bit [popa_pkg::SLOT_W-1:0] stack_mem [popa_pkg::SLOT_CAP];
  bit slot_busy [popa_pkg::SLOT_CAP];
  int unsigned depth, num_issued, pages, live, peak, alloc_sum, free_sum, built;
  popa_pkg::result_t owed_q[$];
  int unsigned failures, results_seen, errs_seen [4];

  function new();
    per_page = 4; page_cap = 0; checks = 0; stride_reg = 16;
    depth = 0; num_issued = 0; pages = 0; live = 0; peak = 0;
    alloc_sum = 0; free_sum = 0; built = 0; failures = 0; results_seen = 0;
    foreach (slot_busy[i]) slot_busy[i] = 0;
    foreach (errs_seen[i]) errs_seen[i] = 0;
  endfunction

  function void set_reg(logic [1:0] idx, int unsigned val);
    case (idx)
      popa_pkg::REG_PER_PAGE: per_page   = val & 'h3f;
      popa_pkg::REG_LIMIT:    page_cap   = val & 'h1f;
      popa_pkg::REG_CHECK:    checks     = val & 1;
      popa_pkg::REG_STRIDE:   stride_reg = val & 'h7ff;
      default: ;
    endcase
  endfunction

  function int unsigned stride();
    if (stride_reg == 0) return 1;
    return (stride_reg > popa_pkg::MAX_STRIDE) ? popa_pkg::MAX_STRIDE : stride_reg;
  endfunction

  function bit grow_pool();
    int unsigned n, lim;
    lim = (page_cap == 0 || page_cap > popa_pkg::MAX_PAGES) ? popa_pkg::MAX_PAGES : page_cap;
    if (pages >= lim) return 0;
    n = (per_page == 0) ? 1 : (per_page > popa_pkg::MAX_SLOTS_PER_PAGE) ?
        popa_pkg::MAX_SLOTS_PER_PAGE : per_page;
    for (int i = 0; i < n; i++)
      if (built < popa_pkg::SLOT_CAP && depth < popa_pkg::SLOT_CAP) begin
        stack_mem[depth] = popa_pkg::SLOT_W'(built);
        depth++;
        built++;
      end
    pages++;
    return 1;
  endfunction

  // Work out the result of one accepted request and queue it.
  function void note(popa_pkg::req_t r);
    popa_pkg::result_t e;
    int unsigned idx, st;
    bit ok;
    popa_pkg::err_t code;
    st = stride();
    e = '0;
    code = popa_pkg::ERR_OK;
    if (r.kind == popa_pkg::KIND_ALLOC) begin
      ok = 1;
      if (depth == 0) ok = grow_pool();
      if (!ok || depth == 0) code = popa_pkg::ERR_NO_PAGE;
      else begin
        depth--;
        idx = stack_mem[depth];
        num_issued++;
        alloc_sum++;
        slot_busy[idx] = 1;
        if (live < popa_pkg::SLOT_CAP) live++;
        if (live > peak) peak = live;
        e.given_address = popa_pkg::ADDR_W'(idx * st);
        e.given_number  = num_issued;
      end
    end else begin
      idx = r.object_address / st;
      if (checks != 0) begin
        if (r.object_address % st != 0 || idx >= built) code = popa_pkg::ERR_BOUND;
        else if (!slot_busy[idx]) code = popa_pkg::ERR_DOUBLE;
      end
      if (code == popa_pkg::ERR_OK && idx < built) begin
        slot_busy[idx] = 0;
        if (depth < built && depth < popa_pkg::SLOT_CAP) begin
          stack_mem[depth] = popa_pkg::SLOT_W'(idx);
          depth++;
        end
        if (live > 0) live--;
        free_sum++;
      end
    end
    e.error_code        = code;
    e.count_in_use      = popa_pkg::CNT_W'(live);
    e.count_free        = popa_pkg::CNT_W'(depth);
    e.count_pages       = popa_pkg::PAGE_W'(pages);
    e.peak_in_use       = popa_pkg::CNT_W'(peak);
    e.total_allocations = alloc_sum;
    e.total_frees       = free_sum;
    errs_seen[code]++;
    owed_q.push_back(e);
  endfunction

  function void check(popa_pkg::result_t a);
    popa_pkg::result_t e;
    results_seen++;
    if (owed_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, a);
      failures++;
      return;
    end
    e = owed_q.pop_front();
    if (a.given_address !== e.given_address)
      $display("%0t: given_address exp %0d got %0d", $time, e.given_address, a.given_address);
    if (a.given_number !== e.given_number)
      $display("%0t: given_number exp %0d got %0d", $time, e.given_number, a.given_number);
    if (a.error_code !== e.error_code)
      $display("%0t: error_code exp %0d got %0d", $time, e.error_code, a.error_code);
    if (a.count_in_use !== e.count_in_use)
      $display("%0t: count_in_use exp %0d got %0d", $time, e.count_in_use, a.count_in_use);
    if (a.count_free !== e.count_free)
      $display("%0t: count_free exp %0d got %0d", $time, e.count_free, a.count_free);
    if (a.count_pages !== e.count_pages)
      $display("%0t: count_pages exp %0d got %0d", $time, e.count_pages, a.count_pages);
    if (a.peak_in_use !== e.peak_in_use)
      $display("%0t: peak_in_use exp %0d got %0d", $time, e.peak_in_use, a.peak_in_use);
    if (a.total_allocations !== e.total_allocations)
      $display("%0t: total_allocations exp %0d got %0d", $time,
               e.total_allocations, a.total_allocations);
    if (a.total_frees !== e.total_frees)
      $display("%0t: total_frees exp %0d got %0d", $time, e.total_frees, a.total_frees);
    if (a !== e) failures++;
  endfunction
endclass

module tb_paged_object_pool_allocator;
  import popa_pkg::*;

  localparam int STALL_LIMIT = 3000;   // idle cycles before declaring a hang

  logic clk, rst_n, start, busy, out_valid;
  req_t in_req;
  result_t out_result;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  pool_scoreboard pool;
  int unsigned idle_cycles, items_sent, burst_left;
  bit accepted_now;

  paged_object_pool_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_result(out_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Check every strobed result; the receiver can never stall the block.
  // Also run the hang watchdog: any accepted item or result resets it.
  always @(posedge clk) begin
    if (rst_n && out_valid) pool.check(out_result);
    if (!rst_n || out_valid || accepted_now) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout at %0t, %0d results still owed", $time, pool.owed_q.size());
      $display("paged_object_pool_allocator test failed");
      $finish;
    end
  end

  // Hold start high until the block takes the item; leave start high so a
  // following item in the same burst goes back to back.
  task automatic send(input logic kind, input logic [ADDR_W-1:0] addr);
    req_t r;
    r.kind = kind;
    r.object_address = addr;
    start  <= 1'b1;
    in_req <= r;
    do begin
      @(posedge clk);
      accepted_now = 0;
    end while (busy);
    accepted_now = 1;
    pool.note(r);
    items_sent++;
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
    accepted_now = 0;
  endtask

  // Wait out every owed result plus the longest page fill, so the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    accepted_now = 0;
    while (pool.owed_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Setup phase, access phase, then idle before the next transfer.
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pool.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(input int unsigned ppg, lim, chk, strd);
    write_reg(REG_PER_PAGE, ppg);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_CHECK, chk);
    write_reg(REG_STRIDE, strd);
  endtask

  // Pick a free address: mostly a slot now held, else an idle slot,
  // a misaligned one, or raw noise over the whole field.
  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned st, idx, sel;
    st  = pool.stride();
    sel = $urandom_range(99);
    if (pool.built == 0 || sel >= 90) return ADDR_W'($urandom);
    idx = $urandom_range(pool.built - 1);
    if (sel < 70)
      for (int t = 0; t < 12 && !pool.slot_busy[idx]; t++) idx = $urandom_range(pool.built - 1);
    if (sel >= 82 && st > 1) return ADDR_W'(idx * st + $urandom_range(st - 1, 1));
    return ADDR_W'(idx * st);
  endfunction

  // One random phase: bursts of requests, random gaps, alloc bias per phase.
  task automatic random_phase(input int unsigned count, input int unsigned alloc_pct,
                              input bit hold_mid);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 1);
        if ($urandom_range(3) != 0) pause($urandom_range(8, 1));
      end
      burst_left--;
      // hold off once mid-phase until the block has answered everything
      if (hold_mid && i == count / 2) drain();
      if ($urandom_range(99) < alloc_pct) send(KIND_ALLOC, ADDR_W'($urandom));
      else send(KIND_FREE, pick_addr());
    end
    drain();
  endtask

  initial begin
    pool = new();
    accepted_now = 0;
    idle_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    rst_n = 0; start = 0; in_req = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: page limit, every error, unchecked frees of idle and
    // out-of-pool slots, and out-of-range register values.
    set_all(2, 1, 1, 16);
    send(KIND_ALLOC, '0);
    send(KIND_ALLOC, '1);
    send(KIND_ALLOC, '0);              // limit reached
    send(KIND_FREE, 19'd16);
    send(KIND_FREE, 19'd16);           // already free
    send(KIND_FREE, 19'd3);            // misaligned
    send(KIND_FREE, 19'd32);           // beyond the built slots
    send(KIND_FREE, 19'd0);
    drain();
    write_reg(REG_CHECK, 0);
    send(KIND_FREE, 19'd0);            // idle slot, push dropped
    send(KIND_FREE, 19'd5);            // remainder dropped
    send(KIND_FREE, '1);               // ignored
    drain();
    set_all(0, 0, 0, 0);               // zero registers: per-page and stride act as 1, limit as the maximum
    repeat (3) send(KIND_ALLOC, '0);
    send(KIND_FREE, 19'd1);
    drain();
    set_all(63, 31, 1, 2047);          // oversize registers clamp
    repeat (3) send(KIND_ALLOC, '0);
    send(KIND_FREE, 19'd1024);
    send(KIND_FREE, 19'd1025);
    drain();

    // Random phases across settings; each starts from the current pool.
    set_all(4, 0, 1, 16);
    random_phase(250, 60, 1);
    set_all(32, 16, 1, 1024);
    random_phase(250, 55, 0);
    set_all(1, 3, 0, 1);
    random_phase(200, 50, 0);
    set_all($urandom_range(32, 1), $urandom_range(16), 1, $urandom_range(1024, 1));
    random_phase(250, 45, 0);
    set_all($urandom_range(63), $urandom_range(31), 0, $urandom_range(2047));
    random_phase(200, 50, 0);
    set_all(7, 0, 1, 24);
    random_phase(250, 80, 0);

    $display("covered %0d requests, %0d results; errors ok/no_page/bound/double: %0d/%0d/%0d/%0d",
             items_sent, pool.results_seen, pool.errs_seen[0], pool.errs_seen[1],
             pool.errs_seen[2], pool.errs_seen[3]);
    $display("final pool: %0d pages, %0d slots built, %0d in use", pool.pages, pool.built,
             pool.live);
    if (pool.failures == 0 && pool.owed_q.size() == 0)
      $display("paged_object_pool_allocator test passed");
    else
      $display("paged_object_pool_allocator test failed");
    $finish;
  end
endmodule
